// ===== hdl/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared constants, the register file type and the response image mux for
// the Modbus slave register responder.
// ----------------------------------------------------------------------------
package mbs_pkg;

    localparam int FRAME_LEN   = 8;
    localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
    localparam int IMAGE_LEN   = 15;
    localparam int RESP_LEN    = IMAGE_LEN + 2;
    localparam int RESP_IDX_W  = $clog2(RESP_LEN);

    localparam logic [15:0] COUNT_MAX     = 16'd9999;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd30;

    localparam logic [7:0] FN_READ    = 8'h03;
    localparam logic [7:0] FN_WRITE   = 8'h06;
    localparam logic [7:0] BYTE_COUNT = 8'h0C;

    localparam logic [7:0] REG_COUNT   = 8'd4;
    localparam logic [7:0] REG_ADDRESS = 8'd5;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_BYTE   = 2'd1;
    localparam logic [1:0] ACT_BUTTON = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0]       addr;
        logic [3:0][7:0]  err;
        logic [15:0]      count;
    } mbs_regs_t;

    function automatic logic [7:0] image_byte(input logic [3:0] idx, input mbs_regs_t regs);
        logic [7:0] b;
        case (idx)
            4'd0:    b = regs.addr;
            4'd1:    b = FN_READ;
            4'd2:    b = BYTE_COUNT;
            4'd4:    b = regs.err[0];
            4'd6:    b = regs.err[1];
            4'd8:    b = regs.err[2];
            4'd10:   b = regs.err[3];
            4'd11:   b = regs.count[15:8];
            4'd12:   b = regs.count[7:0];
            4'd14:   b = regs.addr;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/modbus_slave_register_responder_top.sv =====
// ----------------------------------------------------------------------------
// modbus_slave_register_responder_top
// Modbus RTU slave with four error flags, an event counter and the slave
// address. Collects eight-byte frames, serves function 3 reads with a CRC
// protected register image and function 6 register writes, and handles
// active-low button samples.
//
//   Channel   Direction  Word contents
//   s_        in         tuser: action[1:0]; tdata: rx_byte[7:0], button_levels[13:8]
//   m_        out        tdata: tx_byte[7:0]; tlast: tx_last
//   cfg_      in         cfg_data: frame_timeout_ticks[7:0]
//
// A tick, a received byte or a button sample is taken whenever the input is ready.
// A completed read frame starts a 17-word response; each of the 15 image words
// is folded into the bit-serial CRC engine before the next one is loaded, and
// the two CRC words follow directly, subject to any output stall.
// The input is not ready while a response is being built.
// Reset is synchronous and active low, with no clearing pass.
// ----------------------------------------------------------------------------
module modbus_slave_register_responder_top
    import mbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // action[1:0]
    input  logic [15:0] s_tdata,   // rx_byte[7:0], button_levels[13:8], zero[15:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte[7:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0]             timeout_reg;
    logic [15:0]            ticks_reg, ticks_next;
    logic [FRAME_IDX_W-1:0] fill_reg, fill_next;
    logic [5:0]             held_reg, held_next;
    mbs_regs_t              regs_reg, regs_next;
    logic [7:0]             frame_reg [FRAME_LEN];

    logic                   accept;
    logic [7:0]             rx_byte;
    logic [5:0]             levels;
    logic [5:0]             pressed;
    logic [FRAME_IDX_W-1:0] fill_eff;
    logic                   frame_full;
    logic                   addr_hit;
    logic                   resp_start;
    logic                   resp_busy;
    logic [15:0]            count_up;

    assign accept  = s_tvalid && s_tready;
    assign rx_byte = s_tdata[7:0];
    assign levels  = s_tdata[13:8];
    assign pressed = ~levels & ~held_reg;

    assign fill_eff   = (ticks_reg > {8'h00, timeout_reg}) ? '0 : fill_reg;
    assign frame_full = (fill_eff == FRAME_IDX_W'(FRAME_LEN - 1));
    assign addr_hit   = (frame_reg[0] == regs_reg.addr);

    always_comb begin
        ticks_next = ticks_reg;
        fill_next  = fill_reg;
        held_next  = held_reg;
        regs_next  = regs_reg;
        resp_start = 1'b0;
        count_up   = regs_reg.count;
        if (accept) begin
            case (s_tuser)
                ACT_TICK: begin
                    if (ticks_reg != TICKS_MAX) begin
                        ticks_next = ticks_reg + 16'd1;
                    end
                end
                ACT_BYTE: begin
                    if (ticks_reg > {8'h00, timeout_reg}) begin
                        ticks_next = 16'd0;
                    end
                    fill_next = fill_eff + 1'b1;
                    if (frame_full && addr_hit) begin
                        if (frame_reg[1] == FN_READ) begin
                            resp_start = 1'b1;
                        end else if (frame_reg[1] == FN_WRITE) begin
                            if (frame_reg[3] < REG_COUNT) begin
                                regs_next.err[frame_reg[3][1:0]] = frame_reg[5];
                            end else if (frame_reg[3] == REG_COUNT) begin
                                regs_next.count = {frame_reg[4], frame_reg[5]};
                            end else if (frame_reg[3] == REG_ADDRESS) begin
                                regs_next.addr = frame_reg[5];
                            end
                        end
                    end
                end
                ACT_BUTTON: begin
                    held_next = ~levels;
                    if (pressed[0] && regs_reg.count < COUNT_MAX) begin
                        count_up = regs_reg.count + 16'd1;
                    end
                    regs_next.count = count_up;
                    if (pressed[1] && count_up != 16'd0) begin
                        regs_next.count = count_up - 16'd1;
                    end
                    for (int i = 0; i < 4; i++) begin
                        if (pressed[3'(i + 2)]) begin
                            regs_next.err[2'(i)] = (regs_reg.err[2'(i)] == 8'd1) ? 8'd0 : 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == ACT_BYTE) begin
            frame_reg[fill_eff] <= rx_byte;
        end
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            ticks_reg   <= 16'd0;
            fill_reg    <= '0;
            held_reg    <= 6'd0;
            regs_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
            ticks_reg <= ticks_next;
            fill_reg  <= fill_next;
            held_reg  <= held_next;
            regs_reg  <= regs_next;
        end
    end

    mbs_responder u_resp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (resp_start),
        .regs     (regs_reg),
        .busy     (resp_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign s_tready  = !resp_busy;
    assign cfg_ready = 1'b1;

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        resp_start |=> !s_tready)
        else $error("Input accepted right after a read request");

endmodule

// ===== hdl/mbs_crc_serial.sv =====
// ----------------------------------------------------------------------------
// mbs_crc_serial
// Bit-serial CRC-16 (Modbus) engine. A loaded byte is folded in and then
// shifted through the polynomial one bit per cycle until all its bits are done.
// ----------------------------------------------------------------------------
module mbs_crc_serial
    import mbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        init,
    input  logic        load,
    input  logic [7:0]  data,
    output logic        done,
    output logic [15:0] crc
);

    logic [15:0] crc_reg, crc_next;
    logic [3:0]  cnt_reg, cnt_next;

    always_comb begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (init) begin
            crc_next = CRC_INIT;
            cnt_next = 4'd0;
        end else if (load) begin
            crc_next = crc_reg ^ {8'h00, data};
            cnt_next = 4'd8;
        end else if (cnt_reg != 4'd0) begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (!aresetn) begin
            cnt_reg <= 4'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign done = (cnt_reg == 4'd0);
    assign crc  = crc_reg;

    a_load_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> done)
        else $error("CRC byte loaded while previous byte still shifting");

endmodule

// ===== hdl/mbs_responder.sv =====
// ----------------------------------------------------------------------------
// mbs_responder
// Read response sequencer: walks the register image byte by byte, feeds the
// serial CRC engine, appends the CRC and drives the output word register.
// ----------------------------------------------------------------------------
module mbs_responder
    import mbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  mbs_regs_t   regs,
    output logic        busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    localparam logic [RESP_IDX_W-1:0] IDX_CRC_LO = RESP_IDX_W'(IMAGE_LEN);
    localparam logic [RESP_IDX_W-1:0] IDX_CRC_HI = RESP_IDX_W'(IMAGE_LEN + 1);

    logic [1:0]            state_reg, state_next;
    logic [RESP_IDX_W-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;

    logic        out_free;
    logic [7:0]  sel_byte;
    logic        crc_load;
    logic        crc_done;
    logic [15:0] crc_val;

    mbs_crc_serial u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .init    (start),
        .load    (crc_load),
        .data    (sel_byte),
        .done    (crc_done),
        .crc     (crc_val)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        if (idx_reg == IDX_CRC_LO) begin
            sel_byte = crc_val[7:0];
        end else if (idx_reg == IDX_CRC_HI) begin
            sel_byte = crc_val[15:8];
        end else begin
            sel_byte = image_byte(idx_reg[3:0], regs);
        end
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        crc_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_LOAD;
                    idx_next   = '0;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = sel_byte;
                    out_last_next  = (idx_reg == IDX_CRC_HI);
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg < IDX_CRC_LO) begin
                        crc_load   = 1'b1;
                        state_next = ST_SHIFT;
                    end else if (idx_reg == IDX_CRC_HI) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SHIFT: begin
                if (crc_done) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == ST_IDLE)
        else $error("Response started while a response is in progress");

    a_shift_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && crc_done) |=> state_reg == ST_LOAD)
        else $error("Sequencer did not return to load after CRC byte");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && out_free && idx_reg == IDX_CRC_HI) |=>
            (state_reg == ST_IDLE && m_tlast && m_tvalid))
        else $error("Final response word not marked last");

endmodule
